// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the rtl in this folder
// no dependencies; expects clk and rst_n in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication from one cycle to the next
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/lcl_pwm_pkg.sv =====
// types and constants for the led cube layer pwm scanner
// no dependencies
package lcl_pwm_pkg;

    localparam int DRIVE_W    = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_TICK  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_GAMMA_ZERO  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAMMA_ONE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAMMA_TWO   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAMMA_THREE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_HOLD   = 3'd4;

    localparam logic [1:0]         COLOR_LAST = 2'd2;
    localparam logic [DRIVE_W-1:0] DRIVE_OFF  = 5'b11111;

    typedef enum logic [1:0] {
        PH_SHIFT,
        PH_LATCH,
        PH_HOLD,
        PH_BLANK
    } phase_t;

    typedef struct packed {
        logic       req_type;
        logic [6:0] led_index;
        logic [5:0] led_value;
    } req_t;

    typedef struct packed {
        logic               serial_bit;
        logic               shift_pulse;
        logic               latch_pulse;
        logic [DRIVE_W-1:0] layer_enables_n;
        logic               frame_end;
    } rsp_t;

endpackage

// ===== rtl/core/led_cube_layer_pwm_scanner_core.sv =====
// led cube layer pwm scanner: frame store, scan sequencer and output stages
// depends on lcl_pwm_pkg and assert_macros.svh
//
// usage
//  - req channel (req_valid, req_stall, req): a write item stores one 6-bit led word
//    at led_index (indexes beyond the store are dropped); a tick item produces
//    exactly one rsp item, one output slot, writes produce none
//  - rsp channel (rsp_valid, rsp_stall, rsp): serial data, shift and latch strobes,
//    active-low layer drives and the frame end flag
//  - cfg port: cfg_we, cfg_index, cfg_data; gamma thresholds and the layer-zero
//    hold count; the user must write them only while the block is idle, which it does not enforce
//  - throughput: one item per clock while req_stall is low; the sequencer counters
//    step once per tick and the frame store has one write port and one read port,
//    so a write and a tick never compete
//  - pipeline: a tick loads the frame store read register and the read stage at its
//    accept edge, then the output register once that is free, and is then valid on rsp
//  - when rsp is stalled the output register holds; one more tick still enters the
//    read stage, after which req_stall rises until the output drains
//  - reset: all led words read as dark (per-entry valid bits), counters restart at
//    the top layer, drives all off, thresholds 0/1/3/7 and hold 75
`include "assert_macros.svh"

module led_cube_layer_pwm_scanner_core
    import lcl_pwm_pkg::*;
#(
    parameter int NUM_LAYERS     = 5,
    parameter int LEDS_PER_LAYER = 25
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  req_t                  req,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output rsp_t                  rsp,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int DEPTH   = NUM_LAYERS * LEDS_PER_LAYER;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LAYER_W = (NUM_LAYERS > 1) ? $clog2(NUM_LAYERS) : 1;
    localparam int POS_W   = (LEDS_PER_LAYER > 1) ? $clog2(LEDS_PER_LAYER) : 1;
    localparam logic [LAYER_W-1:0] LAYER_LAST = LAYER_W'(NUM_LAYERS - 1);
    localparam logic [POS_W-1:0]   POS_LAST   = POS_W'(LEDS_PER_LAYER - 1);

    // read stage contents: everything but the data bit is settled at accept time
    typedef struct packed {
        logic               is_shift;
        logic [1:0]         color;
        logic [7:0]         subframe;
        logic               latch;
        logic [DRIVE_W-1:0] drive;
        logic               fend;
    } s1_t;

    // configuration registers
    logic [7:0]  gamma0_reg, gamma1_reg, gamma2_reg, gamma3_reg;
    logic [15:0] hold_limit_reg;

    // sequencer state
    phase_t             phase_reg, phase_next;
    logic [LAYER_W-1:0] layer_reg, layer_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [1:0]         color_reg, color_next;
    logic [15:0]        hold_reg, hold_next;
    logic [7:0]         sub_reg, sub_next;
    logic [DRIVE_W-1:0] drive_reg, drive_next;
    logic               fend_next;

    // frame store with per-entry valid bits standing in for the cleared reset value
    logic [5:0]       mem [DEPTH];
    logic [DEPTH-1:0] vld_reg;
    logic [5:0]       rd_reg;
    logic             rd_vld_reg;

    // pipeline
    s1_t  s1_reg;
    logic s1_valid_reg;
    rsp_t rsp_reg, rsp_next;
    logic rsp_valid_reg;

    logic               take, wr_acc, tick_acc, adv, wr_in_range;
    logic [ADDR_W-1:0]  wr_addr, rd_addr;
    logic [DRIVE_W-1:0] latch_drive;
    logic [15:0]        hold_inc;
    logic [8:0]         sub_inc;
    logic [5:0]         word;
    logic [1:0]         level;
    logic [7:0]         thr;

    // handshake: the read stage moves on whenever the output register is free
    assign adv       = !rsp_valid_reg || !rsp_stall;
    assign req_stall = s1_valid_reg && !adv;
    assign take      = req_valid && !req_stall;
    assign wr_acc    = take && (req.req_type == REQ_WRITE);
    assign tick_acc  = take && (req.req_type == REQ_TICK);

    assign wr_in_range = ({25'd0, req.led_index} < 32'(DEPTH));
    assign wr_addr     = ADDR_W'(req.led_index);
    assign rd_addr     = ADDR_W'(32'(layer_reg) * LEDS_PER_LAYER + 32'(pos_reg));

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gamma0_reg     <= 8'd0;
            gamma1_reg     <= 8'd1;
            gamma2_reg     <= 8'd3;
            gamma3_reg     <= 8'd7;
            hold_limit_reg <= 16'd75;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_GAMMA_ZERO:  gamma0_reg     <= cfg_data[7:0];
                CFG_GAMMA_ONE:   gamma1_reg     <= cfg_data[7:0];
                CFG_GAMMA_TWO:   gamma2_reg     <= cfg_data[7:0];
                CFG_GAMMA_THREE: gamma3_reg     <= cfg_data[7:0];
                CFG_LAST_HOLD:   hold_limit_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // frame store array: write on a write item, read on every tick
    always_ff @(posedge clk)
    begin
        if (wr_acc && wr_in_range)
        begin
            mem[wr_addr] <= req.led_value;
        end
        if (tick_acc)
        begin
            rd_reg <= mem[rd_addr];
        end
    end

    // a write lands at its accept edge, so any tick taken after it already sees it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_acc && wr_in_range)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (tick_acc)
            begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    // drive pattern for the latch slot; layers without an enable bit leave all off
    always_comb
    begin
        for (int i = 0; i < DRIVE_W; i++)
        begin
            latch_drive[i] = (32'(layer_reg) != i);
        end
    end

    assign hold_inc = hold_reg + 16'd1;
    assign sub_inc  = {1'b0, sub_reg} + 9'd1;

    // scan sequencer, stepping once per accepted tick
    always_comb
    begin
        phase_next = phase_reg;
        layer_next = layer_reg;
        pos_next   = pos_reg;
        color_next = color_reg;
        hold_next  = hold_reg;
        sub_next   = sub_reg;
        drive_next = drive_reg;
        fend_next  = 1'b0;
        if (tick_acc)
        begin
            unique case (phase_reg)
                PH_SHIFT:
                begin
                    if (color_reg < COLOR_LAST)
                    begin
                        color_next = color_reg + 2'd1;
                    end
                    else
                    begin
                        color_next = 2'd0;
                        if (pos_reg == '0)
                        begin
                            phase_next = PH_LATCH;
                        end
                        else
                        begin
                            pos_next = pos_reg - POS_W'(1);
                        end
                    end
                end
                PH_LATCH:
                begin
                    drive_next = latch_drive;
                    if (layer_reg == '0)
                    begin
                        hold_next  = 16'd0;
                        phase_next = (hold_limit_reg == 16'd0) ? PH_BLANK : PH_HOLD;
                    end
                    else
                    begin
                        layer_next = layer_reg - LAYER_W'(1);
                        pos_next   = POS_LAST;
                        color_next = 2'd0;
                        phase_next = PH_SHIFT;
                    end
                end
                PH_HOLD:
                begin
                    hold_next = hold_inc;
                    if (hold_inc >= hold_limit_reg)
                    begin
                        phase_next = PH_BLANK;
                    end
                end
                PH_BLANK:
                begin
                    drive_next = DRIVE_OFF;
                    // subframe wraps once it reaches the level three threshold
                    if (sub_inc >= {1'b0, gamma3_reg})
                    begin
                        sub_next  = 8'd0;
                        fend_next = 1'b1;
                    end
                    else
                    begin
                        sub_next = sub_inc[7:0];
                    end
                    layer_next = LAYER_LAST;
                    pos_next   = POS_LAST;
                    color_next = 2'd0;
                    hold_next  = 16'd0;
                    phase_next = PH_SHIFT;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SHIFT;
            layer_reg <= LAYER_LAST;
            pos_reg   <= POS_LAST;
            color_reg <= 2'd0;
            hold_reg  <= 16'd0;
            sub_reg   <= 8'd0;
            drive_reg <= DRIVE_OFF;
        end
        else
        begin
            phase_reg <= phase_next;
            layer_reg <= layer_next;
            pos_reg   <= pos_next;
            color_reg <= color_next;
            hold_reg  <= hold_next;
            sub_reg   <= sub_next;
            drive_reg <= drive_next;
        end
    end

    // read stage: holds the slot while the output register is stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (tick_acc)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_acc)
        begin
            s1_reg.is_shift <= (phase_reg == PH_SHIFT);
            s1_reg.color    <= color_reg;
            s1_reg.subframe <= sub_reg;
            s1_reg.latch    <= (phase_reg == PH_LATCH);
            s1_reg.drive    <= drive_next;
            s1_reg.fend     <= fend_next;
        end
    end

    // data bit: low (lit) while the subframe count is below the level's threshold
    assign word = rd_vld_reg ? rd_reg : 6'd0;

    always_comb
    begin
        case (s1_reg.color)
            2'd0:    level = word[1:0];
            2'd1:    level = word[3:2];
            default: level = word[5:4];
        endcase
        case (level)
            2'd0:    thr = gamma0_reg;
            2'd1:    thr = gamma1_reg;
            2'd2:    thr = gamma2_reg;
            default: thr = gamma3_reg;
        endcase
        rsp_next.serial_bit      = s1_reg.is_shift && !(s1_reg.subframe < thr);
        rsp_next.shift_pulse     = s1_reg.is_shift;
        rsp_next.latch_pulse     = s1_reg.latch;
        rsp_next.layer_enables_n = s1_reg.drive;
        rsp_next.frame_end       = s1_reg.fend;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            rsp_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && s1_valid_reg)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // checks
    `ASSERT_CLK(a_stall_cause, !req_stall || (s1_valid_reg && rsp_valid_reg && rsp_stall),
        "input stalled without a full pipeline")
    `ASSERT_CLK(a_fend_blank, !(rsp_valid && rsp.frame_end) || (rsp.layer_enables_n == DRIVE_OFF),
        "frame end with a layer still driven")
    `ASSERT_CLK(a_one_strobe, !(rsp_valid && rsp.shift_pulse && rsp.latch_pulse),
        "shift and latch in the same slot")
    `ASSERT_NEXT(a_tick_loads, tick_acc, s1_valid_reg,
        "tick not captured by the read stage")

endmodule
